/* hw/rtl/hsv2rgb_pkg.sv */
// Shared types, constants and constant-divide helpers for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    // Field widths
    localparam int HUE_W = 9;
    localparam int CH_W  = 8;
    localparam int REM_W = 6;
    localparam int SEC_W = 4;

    // Scale constants
    localparam logic [CH_W-1:0]  PCT_MAX   = 8'd100;
    localparam logic [REM_W-1:0] SECT_PCT  = 6'd60;
    localparam logic [REM_W-1:0] SECT_BYTE = 6'd43;

    // Thresholds needed to cover the whole hue range at the smallest sector size
    localparam int SECT_CMP = ((2 ** HUE_W) - 1) / 43;

    // Scale mode codes
    localparam logic MODE_PCT  = 1'b0;
    localparam logic MODE_BYTE = 1'b1;

    // Sector codes: the six hue sectors; anything larger maps to black
    localparam logic [SEC_W-1:0] SEC_RY = 4'd0;
    localparam logic [SEC_W-1:0] SEC_YG = 4'd1;
    localparam logic [SEC_W-1:0] SEC_GC = 4'd2;
    localparam logic [SEC_W-1:0] SEC_CB = 4'd3;
    localparam logic [SEC_W-1:0] SEC_BM = 4'd4;
    localparam logic [SEC_W-1:0] SEC_MR = 4'd5;

    // Word leaving the sector stage
    typedef struct packed {
        logic             mode;
        logic [SEC_W-1:0] sector;
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } front_t;

    // Word leaving the level stages
    typedef struct packed {
        logic             mode;
        logic [SEC_W-1:0] sector;
        logic [CH_W-1:0]  val;
        logic [CH_W-1:0]  lo;
        logic [CH_W-1:0]  up;
        logic [CH_W-1:0]  down;
    } level_t;

    // x / 100 for x up to 16383, by reciprocal 5243 / 2^19
    function automatic logic [CH_W-1:0] div100(input logic [13:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(5243);
        return prod[26:19];
    endfunction

    // x / 60 for x up to 8191, by reciprocal 17477 / 2^20
    function automatic logic [CH_W-1:0] div60(input logic [12:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(17477);
        return prod[27:20];
    endfunction

    // x / 43 for x up to 11007, by reciprocal 24386 / 2^20 (result stays below 256)
    function automatic logic [CH_W-1:0] div43(input logic [13:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'(24386);
        return prod[27:20];
    endfunction

    // x * 255 / 100 for x up to 100, folded into one constant multiply
    function automatic logic [CH_W-1:0] pct_to_byte(input logic [CH_W-1:0] x);
        logic [28:0] prod;
        prod = 29'(x) * 29'(1336965);
        return prod[26:19];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter_top.sv */
// Top level of the pipelined HSV to RGB converter with its scale mode register.
//
//  Channel   Valid / stall           Word
//  in        in_valid / in_stall     hue[8:0], saturation[7:0], brightness[7:0]
//  out       out_valid / out_stall   red[7:0], green[7:0], blue[7:0]
//  cfg       cfg_we (no stall)       cfg_wdata[0] = scale_mode
//
//  One word enters every cycle while in_stall is low; each word passes through the registered
//  stages in order (one sector stage, four level stages, one output stage).
//  Reset clears all stage valid bits and sets scale_mode to percent mode.
//  A stall from the output freezes only the stages holding words; empty stages
//  keep filling, so bubbles close up and nothing is dropped or repeated.
//  The scale mode travels with each word, so changing it affects only later words.
`default_nettype none

module hsv_to_rgb_converter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0] hue,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]  saturation,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]  brightness,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]       red,
    output logic [hsv2rgb_pkg::CH_W-1:0]       green,
    output logic [hsv2rgb_pkg::CH_W-1:0]       blue
);
    import hsv2rgb_pkg::*;

    logic   scale_mode_reg;
    logic   fr_valid;
    logic   fr_stall;
    front_t fr_word;
    logic   lv_valid;
    logic   lv_stall;
    level_t lv_word;

    // Scale mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mode_reg <= MODE_PCT;
        end
        else if (cfg_we)
        begin
            scale_mode_reg <= cfg_wdata;
        end
    end

    hsv2rgb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (scale_mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (fr_valid),
        .out_stall  (fr_stall),
        .out_word   (fr_word)
    );

    hsv2rgb_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .in_word   (fr_word),
        .out_valid (lv_valid),
        .out_stall (lv_stall),
        .out_word  (lv_word)
    );

    hsv2rgb_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lv_valid),
        .in_stall  (lv_stall),
        .in_word   (lv_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_front.sv */
// Input stage: clamp saturation and value in percent mode, split hue into sector and offset.
`default_nettype none

module hsv2rgb_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           mode,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]   saturation,
    input  wire logic [hsv2rgb_pkg::CH_W-1:0]   brightness,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output hsv2rgb_pkg::front_t                 out_word
);
    import hsv2rgb_pkg::*;

    logic                 vld_reg;
    logic                 adv;
    logic [REM_W-1:0]     csize;
    logic [SECT_CMP-1:0]  ge;
    logic [HUE_W:0]       thr;
    logic [HUE_W:0]       base;
    front_t               word_next;
    front_t               word_reg;

    // Advance when empty or when the next stage takes the word
    assign adv      = !vld_reg || !out_stall;
    assign in_stall = !adv;

    // Sector by counting thresholds passed, offset by subtracting sector base
    always_comb
    begin
        csize = (mode == MODE_BYTE) ? SECT_BYTE : SECT_PCT;
        thr   = '0;
        for (int k = 0; k < SECT_CMP; k++)
        begin
            thr   = (HUE_W+1)'(k + 1) * (HUE_W+1)'(csize);
            ge[k] = ((HUE_W+1)'(hue) >= thr);
        end
        word_next.mode   = mode;
        word_next.sector = SEC_W'($countones(ge));
        base             = (HUE_W+1)'(word_next.sector) * (HUE_W+1)'(csize);
        word_next.rem    = REM_W'((HUE_W+1)'(hue) - base);
        word_next.sat    = saturation;
        word_next.val    = brightness;
        if (mode == MODE_PCT && saturation > PCT_MAX)
        begin
            word_next.sat = PCT_MAX;
        end
        if (mode == MODE_PCT && brightness > PCT_MAX)
        begin
            word_next.val = PCT_MAX;
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_level.sv */
// Four arithmetic stages: saturation product, lowest level, ramp product, ramp divide with rising and falling levels.
`default_nettype none

module hsv2rgb_level (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire hsv2rgb_pkg::front_t  in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output hsv2rgb_pkg::level_t       out_word
);
    import hsv2rgb_pkg::*;

    localparam int NSTG = 4;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    // Stage 1: saturation complement times value
    logic             s1_mode_reg;
    logic [SEC_W-1:0] s1_sector_reg;
    logic [REM_W-1:0] s1_rem_reg;
    logic [CH_W-1:0]  s1_val_reg;
    logic [15:0]      s1_prod_reg;
    logic [CH_W:0]    s1_comp;

    // Stage 2: lowest level
    logic             s2_mode_reg;
    logic [SEC_W-1:0] s2_sector_reg;
    logic [REM_W-1:0] s2_rem_reg;
    logic [CH_W-1:0]  s2_val_reg;
    logic [CH_W-1:0]  s2_lo_reg;
    logic [CH_W-1:0]  s2_lo_next;

    // Stage 3: span times offset
    logic             s3_mode_reg;
    logic [SEC_W-1:0] s3_sector_reg;
    logic [CH_W-1:0]  s3_val_reg;
    logic [CH_W-1:0]  s3_lo_reg;
    logic [13:0]      s3_q_reg;

    // Stage 4: ramp and the two ramps
    level_t           s4_word_reg;
    level_t           s4_word_next;
    logic [CH_W-1:0]  ramp;

    // Advance chain, from the output back to the input
    assign adv[3]   = !vld_reg[3] || !out_stall;
    assign adv[2]   = !vld_reg[2] || adv[3];
    assign adv[1]   = !vld_reg[1] || adv[2];
    assign adv[0]   = !vld_reg[0] || adv[1];
    assign in_stall = !adv[0];

    // Complement of saturation on the active scale
    assign s1_comp = (in_word.mode == MODE_BYTE) ? ((CH_W+1)'(256) - (CH_W+1)'(in_word.sat))
                                                 : ((CH_W+1)'(PCT_MAX) - (CH_W+1)'(in_word.sat));

    // Lowest level: divide by 256 or by 100
    assign s2_lo_next = (s1_mode_reg == MODE_BYTE) ? s1_prod_reg[15:8]
                                                   : div100(s1_prod_reg[13:0]);

    // Ramp and the rising and falling levels
    always_comb
    begin
        ramp = (s3_mode_reg == MODE_BYTE) ? div43(s3_q_reg) : div60(s3_q_reg[12:0]);
        s4_word_next.mode   = s3_mode_reg;
        s4_word_next.sector = s3_sector_reg;
        s4_word_next.val    = s3_val_reg;
        s4_word_next.lo     = s3_lo_reg;
        s4_word_next.up     = s3_lo_reg + ramp;
        s4_word_next.down   = s3_val_reg - ramp;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Payload stages; each holds while stalled
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s1_mode_reg   <= in_word.mode;
            s1_sector_reg <= in_word.sector;
            s1_rem_reg    <= in_word.rem;
            s1_val_reg    <= in_word.val;
            s1_prod_reg   <= 16'((17)'(s1_comp) * (17)'(in_word.val));
        end
        if (adv[1])
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_sector_reg <= s1_sector_reg;
            s2_rem_reg    <= s1_rem_reg;
            s2_val_reg    <= s1_val_reg;
            s2_lo_reg     <= s2_lo_next;
        end
        if (adv[2])
        begin
            s3_mode_reg   <= s2_mode_reg;
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_lo_reg     <= s2_lo_reg;
            s3_q_reg      <= 14'(s2_val_reg - s2_lo_reg) * 14'(s2_rem_reg);
        end
        if (adv[3])
        begin
            s4_word_reg   <= s4_word_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_word  = s4_word_reg;

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_map.sv */
// Output stage: rescale percent levels to bytes and route levels to the channels.
`default_nettype none

module hsv2rgb_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire hsv2rgb_pkg::level_t           in_word,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]       red,
    output logic [hsv2rgb_pkg::CH_W-1:0]       green,
    output logic [hsv2rgb_pkg::CH_W-1:0]       blue
);
    import hsv2rgb_pkg::*;

    logic            vld_reg;
    logic            adv;
    logic [CH_W-1:0] v_s;
    logic [CH_W-1:0] lo_s;
    logic [CH_W-1:0] up_s;
    logic [CH_W-1:0] dn_s;
    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;
    logic [CH_W-1:0] red_next;
    logic [CH_W-1:0] green_next;
    logic [CH_W-1:0] blue_next;

    assign adv      = !vld_reg || !out_stall;
    assign in_stall = !adv;

    // Rescale, then pick channel sources by sector
    always_comb
    begin
        if (in_word.mode == MODE_PCT)
        begin
            v_s  = pct_to_byte(in_word.val);
            lo_s = pct_to_byte(in_word.lo);
            up_s = pct_to_byte(in_word.up);
            dn_s = pct_to_byte(in_word.down);
        end
        else
        begin
            v_s  = in_word.val;
            lo_s = in_word.lo;
            up_s = in_word.up;
            dn_s = in_word.down;
        end
        unique case (in_word.sector)
            SEC_RY:
            begin
                red_next = v_s;  green_next = up_s; blue_next = lo_s;
            end
            SEC_YG:
            begin
                red_next = dn_s; green_next = v_s;  blue_next = lo_s;
            end
            SEC_GC:
            begin
                red_next = lo_s; green_next = v_s;  blue_next = up_s;
            end
            SEC_CB:
            begin
                red_next = lo_s; green_next = dn_s; blue_next = v_s;
            end
            SEC_BM:
            begin
                red_next = up_s; green_next = lo_s; blue_next = v_s;
            end
            SEC_MR:
            begin
                red_next = v_s;  green_next = lo_s; blue_next = dn_s;
            end
            default:
            begin
                // Hue past the last sector gives black
                red_next = '0;   green_next = '0;   blue_next = '0;
            end
        endcase
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= in_valid;
        end
    end

    // Output register; holds while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = vld_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire
